>>> rtl/core/aescbc_pkg.sv
// Shared types, constants and byte functions for the AES-128 CBC encryption block.
`default_nettype none
package aescbc_pkg;

  localparam int NUM_KEYS = 11;
  localparam int KEY_IDX_W = 4;
  localparam logic [KEY_IDX_W-1:0] LAST_ROUND = 4'd10;
  localparam logic CMD_LOAD_KEY = 1'b0;
  localparam logic CMD_ENCRYPT = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  key_slot;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic [63:0] chain_hi;
    logic [63:0] chain_lo;
    logic        chain_valid;
  } item_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } result_t;

  typedef struct packed {
    logic first;
    logic mix;
  } round_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/aescbc_round.sv
// One AES round (or the initial key addition) applied to a 128-bit state.
`default_nettype none
module aescbc_round (
  input  wire logic [127:0]           state_in,
  input  wire logic [127:0]           round_key,
  input  wire aescbc_pkg::round_ctl_t ctl,
  output logic [127:0]                state_out
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] k [16];
  logic [7:0] a0, a1, a2, a3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = aescbc_pkg::sub_byte(state_in[127 - 8*i -: 8]);
      k[i] = round_key[127 - 8*i -: 8];
    end
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        t[row + 4*col] = s[row + 4*((col + row) % 4)];
      end
    end
    a0 = '0;
    a1 = '0;
    a2 = '0;
    a3 = '0;
    for (int col = 0; col < 4; col++) begin
      a0 = t[4*col];
      a1 = t[4*col + 1];
      a2 = t[4*col + 2];
      a3 = t[4*col + 3];
      if (ctl.mix) begin
        m[4*col]     = aescbc_pkg::xtime(a0) ^ aescbc_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
        m[4*col + 1] = a0 ^ aescbc_pkg::xtime(a1) ^ aescbc_pkg::xtime(a2) ^ a2 ^ a3;
        m[4*col + 2] = a0 ^ a1 ^ aescbc_pkg::xtime(a2) ^ aescbc_pkg::xtime(a3) ^ a3;
        m[4*col + 3] = aescbc_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aescbc_pkg::xtime(a3);
      end else begin
        m[4*col]     = a0;
        m[4*col + 1] = a1;
        m[4*col + 2] = a2;
        m[4*col + 3] = a3;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (ctl.first) begin
        state_out[127 - 8*i -: 8] = state_in[127 - 8*i -: 8] ^ k[i];
      end else begin
        state_out[127 - 8*i -: 8] = m[i] ^ k[i];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/aes128_cbc_block_encrypt.sv
// Top level of the AES-128 encryption block with CBC chaining XOR and a round key store.
//
// The item channel carries one word per command. A load word (cmd 0) writes
// round key key_slot (0 to 10) into an on-chip store and gives no result;
// slots above 10 are dropped. An encrypt word (cmd 1) XORs the chaining
// value into the plaintext when chain_valid is set and then runs AES-128
// with the stored keys.
// A single round unit is reused, first for the initial key addition and then
// for each of the ten rounds, with the next round key read from the store in
// the cycle before it is needed. A result word is loaded after the last round,
// and item_ready returns at that same edge, so no new word is taken while an
// encryption is running. Load words are taken every cycle while the block is
// idle.
// The result sits in an output register until it is taken; if the receiver
// stalls, a finished encryption waits in the block and no new word is taken.
// Reset clears the control state only. The key store holds garbage until
// written, so every key must be loaded before the first encryption.
`default_nettype none
module aes128_cbc_block_encrypt (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire aescbc_pkg::item_t   item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output aescbc_pkg::result_t      result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]   state;
  logic [1:0]   state_next;
  logic [aescbc_pkg::KEY_IDX_W-1:0] rnd;
  logic [aescbc_pkg::KEY_IDX_W-1:0] rd_addr;
  logic [127:0] blk;
  logic [127:0] key_q;
  logic [127:0] round_out;
  logic [127:0] key_mem [aescbc_pkg::NUM_KEYS];
  logic         accept;
  logic         out_free;
  aescbc_pkg::round_ctl_t ctl;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign ctl.first  = (rnd == '0);
  assign ctl.mix    = (rnd != aescbc_pkg::LAST_ROUND);
  assign rd_addr    = (state == ST_RUN && rnd != aescbc_pkg::LAST_ROUND) ?
                      rnd + 4'd1 : '0;

  always_ff @(posedge clk) begin
    if (accept && item.cmd == aescbc_pkg::CMD_LOAD_KEY &&
        item.key_slot <= aescbc_pkg::LAST_ROUND) begin
      key_mem[item.key_slot] <= {item.block_hi, item.block_lo};
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_mem[rd_addr];
  end

  aescbc_round u_round (
    .state_in  (blk),
    .round_key (key_q),
    .ctl       (ctl),
    .state_out (round_out)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item.cmd == aescbc_pkg::CMD_ENCRYPT) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (rnd == aescbc_pkg::LAST_ROUND) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rnd          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        rnd <= '0;
      end else if (state == ST_RUN) begin
        rnd <= rnd + 4'd1;
      end
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk <= {item.block_hi, item.block_lo} ^
             (item.chain_valid ? {item.chain_hi, item.chain_lo} : 128'd0);
    end else if (state == ST_RUN) begin
      blk <= round_out;
    end
    if (state == ST_DONE && out_free) begin
      result.cipher_hi <= blk[127:64];
      result.cipher_lo <= blk[63:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/aescbc_checker.sv
// Port-level checks for the AES-128 CBC encryption block, bound to its top level.
`default_nettype none
module aescbc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                item_valid,
  input wire logic                item_ready,
  input wire aescbc_pkg::item_t   item,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire aescbc_pkg::result_t result
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped before it was taken");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("result word changed while stalled");

  a_busy_after_encrypt: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.cmd == aescbc_pkg::CMD_ENCRYPT |=> !item_ready)
    else $error("new word taken while an encryption is running");

  a_ready_after_load: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.cmd == aescbc_pkg::CMD_LOAD_KEY |=> item_ready)
    else $error("key load stalled the item channel");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared without a running encryption");

endmodule

bind aes128_cbc_block_encrypt aescbc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
`default_nettype wire
